/* hdl/fehm_pkg.sv */
// fehm_pkg: shared types, constants and color palette for the fire heat map
// depends on nothing; used by fehm_ctrl, fehm_datapath and fire_effect_heat_map

package fehm_pkg;

	localparam int MAP_WIDTH  = 32;
	localparam int MAP_HEIGHT = 32;
	localparam int MAP_CELLS  = MAP_WIDTH * MAP_HEIGHT;
	localparam int ADDR_W     = $clog2(MAP_CELLS);
	localparam int SROW_W     = $clog2(MAP_HEIGHT);

	localparam int OP_W   = 2;
	localparam int COL_W  = 5;
	localparam int ROW_W  = 5;
	localparam int HEAT_W = 6;
	localparam int CHAN_W = 8;

	localparam logic [HEAT_W-1:0] HEAT_MAX  = HEAT_W'(36);
	localparam logic [ROW_W-1:0]  FIRST_ROW = ROW_W'(4);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_READ    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic sweep_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic out_free;
	} status_t;

	function automatic logic [3*CHAN_W-1:0] palette(input logic [HEAT_W-1:0] h);
		logic [3*CHAN_W-1:0] c;
		case (h)
			6'd0:    c = 24'h070707;
			6'd1:    c = 24'h1F0707;
			6'd2:    c = 24'h2F0F07;
			6'd3:    c = 24'h470F07;
			6'd4:    c = 24'h571707;
			6'd5:    c = 24'h671F07;
			6'd6:    c = 24'h771F07;
			6'd7:    c = 24'h8F2707;
			6'd8:    c = 24'h9F2F07;
			6'd9:    c = 24'hAF3F07;
			6'd10:   c = 24'hBF4707;
			6'd11:   c = 24'hC74707;
			6'd12:   c = 24'hDF4F07;
			6'd13:   c = 24'hDF5707;
			6'd14:   c = 24'hDF5707;
			6'd15:   c = 24'hD75F07;
			6'd16:   c = 24'hD75F07;
			6'd17:   c = 24'hD7670F;
			6'd18:   c = 24'hCF6F0F;
			6'd19:   c = 24'hCF770F;
			6'd20:   c = 24'hCF7F0F;
			6'd21:   c = 24'hCF8717;
			6'd22:   c = 24'hC78717;
			6'd23:   c = 24'hC78F17;
			6'd24:   c = 24'hC7971F;
			6'd25:   c = 24'hBF9F1F;
			6'd26:   c = 24'hBF9F1F;
			6'd27:   c = 24'hBFA727;
			6'd28:   c = 24'hBFA727;
			6'd29:   c = 24'hBFAF2F;
			6'd30:   c = 24'hB7AF2F;
			6'd31:   c = 24'hB7B72F;
			6'd32:   c = 24'hB7B737;
			6'd33:   c = 24'hCFCF6F;
			6'd34:   c = 24'hDFDF9F;
			6'd35:   c = 24'hEFEFC7;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

endpackage

/* hdl/fire_effect_heat_map.sv */
// fire_effect_heat_map: top level of the fire heat map, joins controller and datapath
// depends on fehm_pkg, fehm_ctrl, fehm_datapath

// The heat map lives in a single-port 1024 x 6 memory. After reset the block runs a
// clearing pass (one cell a cycle) with item_ready low. Advance, read and no-op do the
// memory read in the accept cycle, then the write-back or palette lookup into the result
// register. Clear goes through the accept cycle, the one-cell-a-cycle memory sweep and the
// result cycle. A result waiting in the output register
// holds the block in its final cycle only, so the next transaction is accepted once the
// result slot frees up.

module fire_effect_heat_map (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [fehm_pkg::OP_W-1:0]     operation,
	input  logic                          random_bit,
	input  logic [fehm_pkg::COL_W-1:0]    column,
	input  logic [fehm_pkg::ROW_W-1:0]    row,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [fehm_pkg::HEAT_W-1:0]   heat,
	output logic [fehm_pkg::CHAN_W-1:0]   red,
	output logic [fehm_pkg::CHAN_W-1:0]   green,
	output logic [fehm_pkg::CHAN_W-1:0]   blue,
	output logic                          sweep_last
);
	import fehm_pkg::*;

	cmd_t    cmd;
	status_t status;

	fehm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.operation  (operation),
		.status     (status),
		.item_ready (item_ready),
		.cmd        (cmd)
	);

	fehm_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operation    (operation),
		.random_bit   (random_bit),
		.column       (column),
		.row          (row),
		.result_ready (result_ready),
		.status       (status),
		.result_valid (result_valid),
		.heat         (heat),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.sweep_last   (sweep_last)
	);

endmodule

/* hdl/fehm_ctrl.sv */
// fehm_ctrl: state machine sequencing clearing sweeps, memory access and result hand-off
// depends on fehm_pkg

module fehm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic [1:0]             operation,
	input  fehm_pkg::status_t      status,
	output logic                   item_ready,
	output fehm_pkg::cmd_t         cmd
);
	import fehm_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep_step = 1'b1;
				if (status.sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					if (op_t'(operation) == OP_CLEAR) begin
						state_d = ST_CLEAR;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_CLEAR: begin
				cmd.sweep_step = 1'b1;
				if (status.sweep_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

endmodule

/* hdl/fehm_datapath.sv */
// fehm_datapath: heat memory, clearing sweep counters, cursor, palette lookup, result register
// depends on fehm_pkg

module fehm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fehm_pkg::cmd_t                cmd,
	input  logic [fehm_pkg::OP_W-1:0]     operation,
	input  logic                          random_bit,
	input  logic [fehm_pkg::COL_W-1:0]    column,
	input  logic [fehm_pkg::ROW_W-1:0]    row,
	input  logic                          result_ready,
	output fehm_pkg::status_t             status,
	output logic                          result_valid,
	output logic [fehm_pkg::HEAT_W-1:0]   heat,
	output logic [fehm_pkg::CHAN_W-1:0]   red,
	output logic [fehm_pkg::CHAN_W-1:0]   green,
	output logic [fehm_pkg::CHAN_W-1:0]   blue,
	output logic                          sweep_last
);
	import fehm_pkg::*;

	logic [HEAT_W-1:0] heat_mem [MAP_CELLS];

	logic [ADDR_W-1:0] sweep_addr_q;
	logic [SROW_W-1:0] sweep_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;

	op_t               op_q;
	logic              bit_q;
	logic              in_map_q;
	logic [HEAT_W-1:0] rd_q;

	logic              result_valid_q;
	logic [HEAT_W-1:0] heat_q;
	logic [CHAN_W-1:0] red_q;
	logic [CHAN_W-1:0] green_q;
	logic [CHAN_W-1:0] blue_q;
	logic              sweep_last_q;

	logic [ADDR_W-1:0]   cur_addr;
	logic [ADDR_W-1:0]   pix_addr;
	logic [ADDR_W-1:0]   rd_addr;
	logic                pix_in_map;
	logic                we;
	logic [ADDR_W-1:0]   wr_addr;
	logic [HEAT_W-1:0]   wr_data;
	logic                rise;
	logic                adv_fin;
	logic                cur_row_end;
	logic                cur_col_end;
	logic [HEAT_W-1:0]   heat_sat;
	logic [3*CHAN_W-1:0] color;

	assign cur_addr   = ADDR_W'(cur_col_q) * ADDR_W'(MAP_HEIGHT) + ADDR_W'(cur_row_q);
	assign pix_addr   = ADDR_W'(column) * ADDR_W'(MAP_HEIGHT) + ADDR_W'(row);
	assign pix_in_map = (32'(column) < MAP_WIDTH) && (32'(row) < MAP_HEIGHT);
	assign rd_addr    = (op_t'(operation) == OP_ADVANCE) ? cur_addr : pix_addr;

	assign adv_fin     = cmd.finish && (op_q == OP_ADVANCE);
	assign rise        = bit_q && (rd_q != '0);
	assign cur_row_end = (cur_row_q == ROW_W'(MAP_HEIGHT - 1));
	assign cur_col_end = (cur_col_q == COL_W'(MAP_WIDTH - 1));

	always_comb begin
		we      = 1'b0;
		wr_addr = sweep_addr_q;
		wr_data = (sweep_row_q == SROW_W'(MAP_HEIGHT - 1)) ? HEAT_MAX : '0;
		if (cmd.sweep_step) begin
			we = 1'b1;
		end else if (adv_fin) begin
			we      = 1'b1;
			wr_addr = cur_addr - ADDR_W'(1) - ADDR_W'(rise);
			wr_data = rd_q - HEAT_W'(rise);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			heat_mem[wr_addr] <= wr_data;
		end
		if (cmd.capture) begin
			rd_q <= heat_mem[rd_addr];
		end
	end

	assign status.sweep_done = (sweep_addr_q == ADDR_W'(MAP_CELLS - 1));
	assign status.out_free   = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q <= '0;
			sweep_row_q  <= '0;
		end else if (cmd.sweep_step) begin
			if (status.sweep_done) begin
				sweep_addr_q <= '0;
			end else begin
				sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
			end
			if (sweep_row_q == SROW_W'(MAP_HEIGHT - 1)) begin
				sweep_row_q <= '0;
			end else begin
				sweep_row_q <= sweep_row_q + SROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= FIRST_ROW;
		end else if (cmd.capture && (op_t'(operation) == OP_CLEAR)) begin
			cur_col_q <= '0;
			cur_row_q <= FIRST_ROW;
		end else if (adv_fin) begin
			if (cur_row_end) begin
				cur_row_q <= FIRST_ROW;
				cur_col_q <= cur_col_end ? '0 : cur_col_q + COL_W'(1);
			end else begin
				cur_row_q <= cur_row_q + ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op_t'(operation);
			bit_q    <= random_bit;
			in_map_q <= pix_in_map;
		end
	end

	assign heat_sat = (rd_q > HEAT_MAX) ? HEAT_MAX : rd_q;
	assign color    = palette(heat_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			heat_q       <= '0;
			red_q        <= '0;
			green_q      <= '0;
			blue_q       <= '0;
			sweep_last_q <= adv_fin && cur_row_end && cur_col_end;
			if ((op_q == OP_READ) && in_map_q) begin
				heat_q  <= heat_sat;
				red_q   <= color[3*CHAN_W-1:2*CHAN_W];
				green_q <= color[2*CHAN_W-1:CHAN_W];
				blue_q  <= color[CHAN_W-1:0];
			end
		end
	end

	assign result_valid = result_valid_q;
	assign heat         = heat_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign sweep_last   = sweep_last_q;

endmodule

/* verif/tb_top.sv */
// tb_top: self-checking testbench for fire_effect_heat_map
// directed table then random traffic, checked against a cycle-free heat map predictor
// depends on fehm_pkg and the fire_effect_heat_map rtl
`timescale 1ns / 100ps

module tb_top;
	import fehm_pkg::*;

	localparam int RANDOM_ITEMS  = 1250;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 16;
	localparam int HOLD_AT       = 300;
	localparam int HOLD_CYCLES   = 400;
	localparam int PAUSE_AT      = 600;
	localparam int QUIET_FIRST   = 800;
	localparam int QUIET_LAST    = 1000;
	localparam int CLEAR_WINDOW  = 150;

	localparam logic [3*CHAN_W-1:0] FIRE_COLORS [37] = '{
		24'h070707, 24'h1F0707, 24'h2F0F07, 24'h470F07, 24'h571707, 24'h671F07,
		24'h771F07, 24'h8F2707, 24'h9F2F07, 24'hAF3F07, 24'hBF4707, 24'hC74707,
		24'hDF4F07, 24'hDF5707, 24'hDF5707, 24'hD75F07, 24'hD75F07, 24'hD7670F,
		24'hCF6F0F, 24'hCF770F, 24'hCF7F0F, 24'hCF8717, 24'hC78717, 24'hC78F17,
		24'hC7971F, 24'hBF9F1F, 24'hBF9F1F, 24'hBFA727, 24'hBFA727, 24'hBFAF2F,
		24'hB7AF2F, 24'hB7B72F, 24'hB7B737, 24'hCFCF6F, 24'hDFDF9F, 24'hEFEFC7,
		24'hFFFFFF
	};

	typedef struct packed {
		logic [HEAT_W-1:0] heat;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              sweep_last;
	} cell_answer_t;

	typedef struct packed {
		op_t                 op;
		logic                rbit;
		logic [COL_W-1:0]    col;
		logic [ROW_W-1:0]    row;
		logic                known;
		logic [HEAT_W-1:0]   heat;
		logic [3*CHAN_W-1:0] rgb;
		logic                sweep;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 16;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{OP_READ,    1'b0, 5'd0,  5'd31, 1'b1, 6'd36, 24'hFFFFFF, 1'b0},
		'{OP_READ,    1'b1, 5'd31, 5'd31, 1'b1, 6'd36, 24'hFFFFFF, 1'b0},
		'{OP_READ,    1'b0, 5'd0,  5'd0,  1'b1, 6'd0,  24'h070707, 1'b0},
		'{OP_READ,    1'b1, 5'd31, 5'd0,  1'b1, 6'd0,  24'h070707, 1'b0},
		'{OP_NONE,    1'b1, 5'd31, 5'd31, 1'b1, 6'd0,  24'h000000, 1'b0},
		'{OP_NONE,    1'b0, 5'd0,  5'd0,  1'b1, 6'd0,  24'h000000, 1'b0},
		'{OP_ADVANCE, 1'b0, 5'd0,  5'd0,  1'b0, 6'd0,  24'h000000, 1'b0},
		'{OP_ADVANCE, 1'b1, 5'd31, 5'd31, 1'b0, 6'd0,  24'h000000, 1'b0},
		'{OP_ADVANCE, 1'b1, 5'd10, 5'd20, 1'b0, 6'd0,  24'h000000, 1'b0},
		'{OP_CLEAR,   1'b1, 5'd31, 5'd31, 1'b1, 6'd0,  24'h000000, 1'b0},
		'{OP_ADVANCE, 1'b0, 5'd0,  5'd0,  1'b0, 6'd0,  24'h000000, 1'b0},
		'{OP_READ,    1'b0, 5'd0,  5'd3,  1'b0, 6'd0,  24'h000000, 1'b0},
		'{OP_READ,    1'b0, 5'd17, 5'd31, 1'b1, 6'd36, 24'hFFFFFF, 1'b0},
		'{OP_CLEAR,   1'b0, 5'd0,  5'd0,  1'b1, 6'd0,  24'h000000, 1'b0},
		'{OP_READ,    1'b1, 5'd21, 5'd21, 1'b0, 6'd0,  24'h000000, 1'b0},
		'{OP_ADVANCE, 1'b1, 5'd5,  5'd9,  1'b0, 6'd0,  24'h000000, 1'b0}
	};

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_ready;
	logic [OP_W-1:0]     operation;
	logic                random_bit;
	logic [COL_W-1:0]    column;
	logic [ROW_W-1:0]    row;
	logic                result_valid;
	logic                result_ready;
	logic [HEAT_W-1:0]   heat;
	logic [CHAN_W-1:0]   red;
	logic [CHAN_W-1:0]   green;
	logic [CHAN_W-1:0]   blue;
	logic                sweep_last;

	logic [HEAT_W-1:0] fire_map [MAP_WIDTH][MAP_HEIGHT];
	int                walk_col;
	int                walk_row;
	cell_answer_t      heat_expect_q [$];
	int                fail_count;
	int                results_seen;
	int                hold_left;
	bit                hold_done;
	bit                sender_quiet;
	int                cycle_count;

	fire_effect_heat_map i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.operation    (operation),
		.random_bit   (random_bit),
		.column       (column),
		.row          (row),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.heat         (heat),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.sweep_last   (sweep_last)
	);

	always #2 clk = ~clk;

	task automatic clear_fire_map();
		for (int c = 0; c < MAP_WIDTH; c++) begin
			for (int r = 0; r < MAP_HEIGHT; r++) begin
				fire_map[c][r] = (r == MAP_HEIGHT - 1) ? HEAT_MAX : '0;
			end
		end
		walk_col = 0;
		walk_row = int'(FIRST_ROW);
	endtask

	task automatic fire_step_predict(input op_t op, input logic rbit,
			input logic [COL_W-1:0] col, input logic [ROW_W-1:0] r,
			output cell_answer_t ans);
		int h;
		ans = '0;
		case (op)
			OP_CLEAR: begin
				clear_fire_map();
			end
			OP_ADVANCE: begin
				h = int'(fire_map[walk_col][walk_row]);
				if (h == 0) begin
					fire_map[walk_col][walk_row - 1] = '0;
				end else begin
					fire_map[walk_col][walk_row - 1 - int'(rbit)] = HEAT_W'(h - int'(rbit));
				end
				walk_row++;
				if (walk_row >= MAP_HEIGHT) begin
					walk_row = int'(FIRST_ROW);
					walk_col++;
					if (walk_col >= MAP_WIDTH) begin
						walk_col = 0;
						ans.sweep_last = 1'b1;
					end
				end
			end
			OP_READ: begin
				if (int'(col) < MAP_WIDTH && int'(r) < MAP_HEIGHT) begin
					h = int'(fire_map[col][r]);
					if (h > int'(HEAT_MAX)) h = int'(HEAT_MAX);
					ans.heat = HEAT_W'(h);
					{ans.red, ans.green, ans.blue} = FIRE_COLORS[h];
				end
			end
			default: begin
			end
		endcase
	endtask

	// drives one transaction, predicts it on acceptance
	task automatic send_item(input op_t op, input logic rbit, input logic [COL_W-1:0] col,
			input logic [ROW_W-1:0] r, input logic known, input cell_answer_t known_ans);
		cell_answer_t ans;
		if (!sender_quiet && $urandom_range(0, 99) < 6) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_valid <= 1'b1;
		operation  <= op;
		random_bit <= rbit;
		column     <= col;
		row        <= r;
		do @(posedge clk); while (!item_ready);
		fire_step_predict(op, rbit, col, r, ans);
		heat_expect_q.push_back(known ? known_ans : ans);
	endtask

	// result side: check, plus randomized ready with one long hold and an always-ready window
	always @(posedge clk) begin
		cell_answer_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (heat_expect_q.size() == 0) begin
				$error("unexpected result transaction");
				fail_count++;
			end else begin
				want = heat_expect_q.pop_front();
				if (heat !== want.heat) begin
					$error("heat: expected %0d, actual %0d", want.heat, heat);
					fail_count++;
				end
				if (red !== want.red) begin
					$error("red: expected %0h, actual %0h", want.red, red);
					fail_count++;
				end
				if (green !== want.green) begin
					$error("green: expected %0h, actual %0h", want.green, green);
					fail_count++;
				end
				if (blue !== want.blue) begin
					$error("blue: expected %0h, actual %0h", want.blue, blue);
					fail_count++;
				end
				if (sweep_last !== want.sweep_last) begin
					$error("sweep_last: expected %0b, actual %0b", want.sweep_last, sweep_last);
					fail_count++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (results_seen == HOLD_AT && !hold_done) begin
			// long back-pressure so the block fills and stalls its input
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			result_ready <= 1'b0;
		end else if (results_seen >= 900 && results_seen < 1100) begin
			result_ready <= 1'b1;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= 6);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[fire_effect_heat_map] ERROR");
			$finish;
		end
	end

	initial begin
		cell_answer_t known_ans;
		op_t          op;
		int           pick;
		clk          = 1'b0;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		operation    = OP_NONE;
		random_bit   = 1'b0;
		column       = '0;
		row          = '0;
		result_ready = 1'b0;
		fail_count   = 0;
		results_seen = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		sender_quiet = 1'b0;
		cycle_count  = 0;
		clear_fire_map();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			known_ans.heat       = DIRECTED[i].heat;
			{known_ans.red, known_ans.green, known_ans.blue} = DIRECTED[i].rgb;
			known_ans.sweep_last = DIRECTED[i].sweep;
			send_item(DIRECTED[i].op, DIRECTED[i].rbit, DIRECTED[i].col, DIRECTED[i].row,
				DIRECTED[i].known, known_ans);
		end

		known_ans = '0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == PAUSE_AT) begin
				item_valid <= 1'b0;
				while (heat_expect_q.size() != 0) @(posedge clk);
			end
			sender_quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
			// clears only early so later traffic can finish whole sweeps
			pick = $urandom_range(0, 999);
			if (pick < 15 && n < CLEAR_WINDOW) op = OP_CLEAR;
			else if (pick < 860) op = OP_ADVANCE;
			else if (pick < 985) op = OP_READ;
			else op = OP_NONE;
			send_item(op, 1'($urandom_range(0, 1)), COL_W'($urandom_range(0, 31)),
				ROW_W'($urandom_range(0, 31)), 1'b0, known_ans);
		end
		item_valid <= 1'b0;

		while (heat_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("[fire_effect_heat_map] OK");
		end else begin
			$display("[fire_effect_heat_map] ERROR");
		end
		$finish;
	end

endmodule
